// File: rtl/lesb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lesb_pkg
// Shared types, codes and constants of the line-editing serial buffer.
// ---------------------------------------------------------------------------
package lesb_pkg;

    // default ring store depth
    localparam int LESB_DEPTH_DEF = 128;

    // stream word widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int CHAR_W      = 8;
    localparam int ID_W        = 4;
    localparam int ECHO_N_W    = 2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    // event kind carried in tuser
    typedef enum logic [IN_TUSER_W-1:0] {
        MODE_UART = 2'd0,
        MODE_PUT  = 2'd1,
        MODE_GET  = 2'd2,
        MODE_NOP  = 2'd3
    } t_mode;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SERVE,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic push;
        logic serve;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic echo_pend;
        logic echo_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/lesb_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lesb_ram
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module lesb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lesb_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lesb_ctrl
// Sequencer: accept and edit, push echo bytes, serve, load the result.
// ---------------------------------------------------------------------------
module lesb_ctrl import lesb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_sts.echo_last) begin
                    n_state = ST_SERVE;
                end
            end
            ST_SERVE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_PUSH: begin
                o_cmd.push = i_sts.echo_pend;
            end
            ST_SERVE: begin
                o_cmd.serve = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/lesb_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lesb_dp
// Datapath: line editing, ring pointers and counts, echo queue, result word.
// ---------------------------------------------------------------------------
module lesb_dp import lesb_pkg::*; #(
    parameter int BUFFER_DEPTH = LESB_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [IN_TDATA_W-1:0]  i_tdata,
    input  logic [IN_TUSER_W-1:0]  i_tuser,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(BUFFER_DEPTH);
    localparam logic [CW:0]   LVL_FULL = (CW + 1)'(BUFFER_DEPTH);

    // input word fields
    t_mode             w_mode;
    logic              w_rxv;
    logic              w_txd;
    logic [CHAR_W-1:0] w_byte;
    logic [ID_W-1:0]   w_req;

    // control state
    logic [PW-1:0] r_iwp, n_iwp, r_irp, n_irp, r_owp, n_owp, r_orp, n_orp;
    logic [CW-1:0] r_ready, n_ready, r_edit, n_edit, r_ocnt, n_ocnt;
    logic          r_wait, n_wait, r_tx_idle, n_tx_idle;
    logic [ID_W-1:0] r_rid, n_rid;
    logic [ECHO_N_W-1:0] r_echo_n, n_echo_n;
    logic          r_ov, n_ov;

    // payload
    logic [3*CHAR_W-1:0] r_echo, n_echo;
    logic          r_put_ref, n_put_ref, r_get_ref, n_get_ref;
    logic          r_srx, n_srx, r_stx, n_stx;
    logic [ID_W-1:0] r_sid, n_sid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    // store ports
    logic              in_we, in_re, out_we, out_re;
    logic [CHAR_W-1:0] in_wdata, in_rdata, out_rdata;

    logic w_full, w_ofull, w_is_bs, w_is_eol, w_is_prt;
    logic [CW:0] w_lvl;

    assign w_mode = t_mode'(i_tuser);
    assign w_rxv  = i_tdata[0];
    assign w_txd  = i_tdata[1];
    assign w_byte = i_tdata[9:2];
    assign w_req  = i_tdata[13:10];

    // line and store occupancy
    assign w_lvl   = {1'b0, r_ready} + {1'b0, r_edit};
    assign w_full  = (w_lvl >= LVL_FULL);
    assign w_ofull = (r_ocnt == CNT_FULL);

    // received byte classes
    assign w_is_bs  = (w_byte == CH_BS) || (w_byte == CH_DEL);
    assign w_is_eol = (w_byte == CH_CR) || (w_byte == CH_LF);
    assign w_is_prt = (w_byte >= CH_SP) && (w_byte < CH_DEL);

    // next values
    always_comb begin
        n_iwp = r_iwp;  n_irp = r_irp;  n_owp = r_owp;  n_orp = r_orp;
        n_ready = r_ready;  n_edit = r_edit;  n_ocnt = r_ocnt;
        n_wait = r_wait;  n_tx_idle = r_tx_idle;  n_rid = r_rid;
        n_echo = r_echo;  n_echo_n = r_echo_n;
        n_put_ref = r_put_ref;  n_get_ref = r_get_ref;
        n_srx = r_srx;  n_stx = r_stx;  n_sid = r_sid;
        n_ov = r_ov;  n_odata = r_odata;
        in_we = 1'b0;  in_wdata = w_byte;  in_re = 1'b0;
        out_we = 1'b0;  out_re = 1'b0;

        // event: edit line, queue echo, put or get
        if (i_cmd.load) begin
            n_put_ref = 1'b0;
            n_get_ref = 1'b0;
            case (w_mode)
                MODE_UART: begin
                    if (w_rxv) begin
                        if (w_is_bs) begin
                            if (r_edit != '0) begin
                                n_edit   = r_edit - CW'(1);
                                n_iwp    = (r_iwp == '0) ? PTR_LAST : r_iwp - PW'(1);
                                n_echo   = {CH_BS, CH_SP, CH_BS};
                                n_echo_n = ECHO_N_W'(3);
                            end
                        end else if (w_is_eol) begin
                            if (!w_full) begin
                                in_we    = 1'b1;
                                in_wdata = CH_LF;
                                n_iwp    = (r_iwp == PTR_LAST) ? '0 : r_iwp + PW'(1);
                                n_ready  = r_ready + r_edit + CW'(1);
                                n_edit   = '0;
                                n_echo   = {{CHAR_W{1'b0}}, CH_LF, CH_CR};
                                n_echo_n = ECHO_N_W'(2);
                            end
                        end else if (w_is_prt) begin
                            if (!w_full) begin
                                in_we    = 1'b1;
                                n_iwp    = (r_iwp == PTR_LAST) ? '0 : r_iwp + PW'(1);
                                n_edit   = r_edit + CW'(1);
                                n_echo   = {{(2*CHAR_W){1'b0}}, w_byte};
                                n_echo_n = ECHO_N_W'(1);
                            end
                        end
                    end
                    if (w_txd) begin
                        n_tx_idle = 1'b1;
                    end
                end
                MODE_PUT: begin
                    n_echo    = {{(2*CHAR_W){1'b0}}, w_byte};
                    n_echo_n  = ECHO_N_W'(1);
                    n_put_ref = w_ofull;
                end
                MODE_GET: begin
                    if (r_wait) begin
                        n_get_ref = 1'b1;
                    end else begin
                        n_wait = 1'b1;
                        n_rid  = w_req;
                    end
                end
                default: begin
                    n_echo_n = '0;
                end
            endcase
        end

        // one queued byte into the transmit store, dropped when full
        if (i_cmd.push) begin
            if (!w_ofull) begin
                out_we = 1'b1;
                n_owp  = (r_owp == PTR_LAST) ? '0 : r_owp + PW'(1);
                n_ocnt = r_ocnt + CW'(1);
            end
            n_echo   = {{CHAR_W{1'b0}}, r_echo[3*CHAR_W-1:CHAR_W]};
            n_echo_n = r_echo_n - ECHO_N_W'(1);
        end

        // serve waiting reader and idle transmitter
        if (i_cmd.serve) begin
            n_srx = r_wait && (r_ready != '0);
            n_stx = r_tx_idle && (r_ocnt != '0);
            n_sid = r_rid;
            if (r_wait && (r_ready != '0)) begin
                in_re   = 1'b1;
                n_irp   = (r_irp == PTR_LAST) ? '0 : r_irp + PW'(1);
                n_ready = r_ready - CW'(1);
                n_wait  = 1'b0;
            end
            if (r_tx_idle && (r_ocnt != '0)) begin
                out_re    = 1'b1;
                n_orp     = (r_orp == PTR_LAST) ? '0 : r_orp + PW'(1);
                n_ocnt    = r_ocnt - CW'(1);
                n_tx_idle = 1'b0;
            end
        end

        // result register
        if (i_cmd.emit) begin
            n_ov    = 1'b1;
            n_odata = {r_get_ref, r_put_ref,
                       r_stx ? out_rdata : {CHAR_W{1'b0}}, r_stx,
                       r_srx ? r_sid : {ID_W{1'b0}},
                       r_srx ? in_rdata : {CHAR_W{1'b0}}, r_srx};
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iwp     <= '0;
            r_irp     <= '0;
            r_owp     <= '0;
            r_orp     <= '0;
            r_ready   <= '0;
            r_edit    <= '0;
            r_ocnt    <= '0;
            r_wait    <= 1'b0;
            r_tx_idle <= 1'b1;
            r_rid     <= '0;
            r_echo_n  <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_iwp     <= n_iwp;
            r_irp     <= n_irp;
            r_owp     <= n_owp;
            r_orp     <= n_orp;
            r_ready   <= n_ready;
            r_edit    <= n_edit;
            r_ocnt    <= n_ocnt;
            r_wait    <= n_wait;
            r_tx_idle <= n_tx_idle;
            r_rid     <= n_rid;
            r_echo_n  <= n_echo_n;
            r_ov      <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_echo    <= n_echo;
        r_put_ref <= n_put_ref;
        r_get_ref <= n_get_ref;
        r_srx     <= n_srx;
        r_stx     <= n_stx;
        r_sid     <= n_sid;
        r_odata   <= n_odata;
    end

    // receive line store
    lesb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (r_iwp),
        .i_wdata (in_wdata),
        .i_re    (in_re),
        .i_raddr (r_irp),
        .o_rdata (in_rdata)
    );

    // transmit store
    lesb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (r_owp),
        .i_wdata (r_echo[CHAR_W-1:0]),
        .i_re    (out_re),
        .i_raddr (r_orp),
        .o_rdata (out_rdata)
    );

    // status and outputs
    assign o_sts.echo_pend = (r_echo_n != '0);
    assign o_sts.echo_last = (r_echo_n <= ECHO_N_W'(1));
    assign o_sts.out_free  = !r_ov || i_out_ready;
    assign o_out_valid     = r_ov;
    assign o_out_data      = r_odata;

endmodule

// File: rtl/line_edit_serial_buffer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_edit_serial_buffer_core
// Canonical tty line discipline with receive-line and transmit ring stores.
// ---------------------------------------------------------------------------
//  channel  dir  tdata (lsb up)                              tuser
//  s_axis   in   rx_valid, tx_done, data_byte, requester_id  mode
//  m_axis   out  reply_valid, reply_char, reply_to,          -
//                tx_valid, tx_char, put_refused, get_refused
//
//  an event is accepted and edited; its echo bytes, three for backspace,
//  two for CR or LF, go one per cycle through the transmit store write
//  port, then a serve step starts the registered store reads
//  reset is synchronous; the ring stores are not cleared, only pointers,
//  counts and control flags, so the block takes a word straight after reset
//  a result waits in the output register while the next word is accepted;
//  the following result waits until that register is free
// ---------------------------------------------------------------------------
module line_edit_serial_buffer_core import lesb_pkg::*; #(
    parameter int BUFFER_DEPTH = LESB_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // rx_valid, tx_done, data_byte, requester_id, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // reply_valid, reply_char, reply_to, tx_valid, tx_char,
    // put_refused, get_refused
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    lesb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    lesb_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    // no new word while echo bytes are still going into the store
    a_push_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> !s_axis_tready)
        else $error("word accepted during echo push");

    // an accepted word occupies the block for at least the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // loading a result always shows it on the output
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("result loaded but not presented");

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.push, cmd.serve, cmd.emit}))
        else $error("overlapping commands");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for line_edit_serial_buffer_core. A short table of
// line edits, puts and gets comes first, then random runs of typing, store
// filling and draining. Every result word is scored against a typed table
// entry or a behavioural model of the line discipline kept alongside the block.
// ---------------------------------------------------------------------------
module testbench;
    import lesb_pkg::*;

    localparam int DEPTH         = LESB_DEPTH_DEF;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_WORDS  = 1276;
    localparam int RUN_LIMIT     = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_MAX    = 10;

    // input word, lsb up: rx_valid, tx_done, data_byte, requester_id, zero fill
    typedef struct packed {
        logic [1:0]        fill;
        logic [ID_W-1:0]   requester_id;
        logic [CHAR_W-1:0] data_byte;
        logic              tx_done;
        logic              rx_valid;
    } t_event_word;

    // result word, lsb up: reply_valid, reply_char, reply_to, tx_valid,
    // tx_char, put_refused, get_refused
    typedef struct packed {
        logic              get_refused;
        logic              put_refused;
        logic [CHAR_W-1:0] tx_char;
        logic              tx_valid;
        logic [ID_W-1:0]   reply_to;
        logic [CHAR_W-1:0] reply_char;
        logic              reply_valid;
    } t_line_result;

    typedef struct packed {
        t_mode        mode;
        t_event_word  word;
        logic         typed;
        t_line_result want;
    } t_stim_row;

    typedef enum logic [1:0] {
        SEG_TYPING,
        SEG_FILL_LINE,
        SEG_FILL_ECHO,
        SEG_DRAIN
    } t_segment;

    typedef enum logic [2:0] {
        W_CHAR,
        W_RUBOUT,
        W_ENTER,
        W_GET,
        W_DONE,
        W_PUT,
        W_NOISE
    } t_word_kind;

    localparam t_line_result NO_RESULT = '0;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // rx_valid, tx_done, data_byte, requester_id, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // mode
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // reply_valid, reply_char, reply_to, tx_valid, tx_char,
    // put_refused, get_refused
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int src_gap_pct  = 23;
    int sink_gap_pct = 60;
    int errors       = 0;

    // line discipline state as the model sees it
    logic [CHAR_W-1:0] line_mem [DEPTH];
    int                line_wr;
    int                line_rd;
    int                lines_ready;
    int                line_len;
    logic [CHAR_W-1:0] tx_mem [DEPTH];
    int                tx_wr;
    int                tx_rd;
    int                tx_count;
    logic              reader_pending;
    logic [ID_W-1:0]   reader_tag;
    logic              uart_idle;

    t_line_result pending_results[$];

    line_edit_serial_buffer_core #(
        .BUFFER_DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // transmit store write; bytes that do not fit are lost
    function automatic void queue_tx(input logic [CHAR_W-1:0] ch);
        if (tx_count < DEPTH) begin
            tx_mem[tx_wr] = ch;
            tx_wr = (tx_wr + 1) % DEPTH;
            tx_count++;
        end
    endfunction

    function automatic void append_line(input logic [CHAR_W-1:0] ch);
        line_mem[line_wr] = ch;
        line_wr = (line_wr + 1) % DEPTH;
        line_len++;
    endfunction

    // one event through the line discipline, returns its result word
    function automatic t_line_result predict_word(input t_mode mode, input t_event_word w);
        t_line_result r;
        logic         full;
        logic [CHAR_W-1:0] ch;
        r    = NO_RESULT;
        ch   = w.data_byte;
        full = (lines_ready + line_len) >= DEPTH;
        case (mode)
            MODE_UART: begin
                if (w.rx_valid) begin
                    if (ch == CH_BS || ch == CH_DEL) begin
                        // rubout only within the line being edited
                        if (line_len > 0) begin
                            line_len--;
                            line_wr = (line_wr + DEPTH - 1) % DEPTH;
                            queue_tx(CH_BS);
                            queue_tx(CH_SP);
                            queue_tx(CH_BS);
                        end
                    end else if (ch == CH_CR || ch == CH_LF) begin
                        if (!full) begin
                            append_line(CH_LF);
                            lines_ready += line_len;
                            line_len = 0;
                            queue_tx(CH_CR);
                            queue_tx(CH_LF);
                        end
                    end else if (ch >= CH_SP && ch < CH_DEL) begin
                        if (!full) begin
                            append_line(ch);
                            queue_tx(ch);
                        end
                    end
                end
                if (w.tx_done) begin
                    uart_idle = 1'b1;
                end
            end
            MODE_PUT: begin
                if (tx_count < DEPTH) begin
                    queue_tx(ch);
                end else begin
                    r.put_refused = 1'b1;
                end
            end
            MODE_GET: begin
                if (reader_pending) begin
                    r.get_refused = 1'b1;
                end else begin
                    reader_pending = 1'b1;
                    reader_tag     = w.requester_id;
                end
            end
            default: ;
        endcase

        // serve the waiting reader
        if (reader_pending && lines_ready > 0) begin
            r.reply_valid  = 1'b1;
            r.reply_char   = line_mem[line_rd];
            r.reply_to     = reader_tag;
            line_rd        = (line_rd + 1) % DEPTH;
            lines_ready--;
            reader_pending = 1'b0;
        end

        // kick the transmitter
        if (uart_idle && tx_count > 0) begin
            r.tx_valid = 1'b1;
            r.tx_char  = tx_mem[tx_rd];
            tx_rd      = (tx_rd + 1) % DEPTH;
            tx_count--;
            uart_idle  = 1'b0;
        end
        return r;
    endfunction

    function automatic t_line_result result_of(input logic rv, input logic [CHAR_W-1:0] rc,
                                               input logic [ID_W-1:0] rto, input logic tv,
                                               input logic [CHAR_W-1:0] tc, input logic pr,
                                               input logic gr);
        t_line_result r;
        r.reply_valid = rv;
        r.reply_char  = rc;
        r.reply_to    = rto;
        r.tx_valid    = tv;
        r.tx_char     = tc;
        r.put_refused = pr;
        r.get_refused = gr;
        return r;
    endfunction

    function automatic t_stim_row stim_row(input t_mode mode, input logic rx, input logic done,
                                           input logic [CHAR_W-1:0] data,
                                           input logic [ID_W-1:0] id, input logic typed,
                                           input t_line_result want);
        t_stim_row row;
        row                   = '0;
        row.mode              = mode;
        row.word.rx_valid     = rx;
        row.word.tx_done      = done;
        row.word.data_byte    = data;
        row.word.requester_id = id;
        row.typed             = typed;
        row.want              = want;
        return row;
    endfunction

    // random word, weighted by the kind of run in progress
    function automatic t_stim_row random_word(input t_segment seg);
        t_stim_row  row;
        t_word_kind kind;
        int         pick;
        row                   = '0;
        row.mode              = MODE_UART;
        row.word.requester_id = ID_W'($urandom_range(15));
        pick                  = $urandom_range(99);
        case (seg)
            SEG_TYPING: begin
                kind = pick < 50 ? W_CHAR : pick < 58 ? W_RUBOUT : pick < 65 ? W_ENTER :
                       pick < 75 ? W_GET : pick < 85 ? W_DONE : pick < 92 ? W_PUT : W_NOISE;
            end
            SEG_FILL_LINE: begin
                kind = pick < 75 ? W_CHAR : pick < 83 ? W_ENTER : pick < 93 ? W_DONE : W_NOISE;
            end
            SEG_FILL_ECHO: begin
                kind = pick < 80 ? W_PUT : pick < 88 ? W_CHAR : pick < 93 ? W_RUBOUT : W_NOISE;
            end
            default: begin
                kind = pick < 45 ? W_GET : pick < 85 ? W_DONE : pick < 90 ? W_RUBOUT : W_NOISE;
            end
        endcase
        case (kind)
            W_CHAR: begin
                row.word.rx_valid  = 1'b1;
                row.word.data_byte = CHAR_W'($urandom_range(8'h7E, 8'h20));
                row.word.tx_done   = ($urandom_range(3) == 0);
            end
            W_RUBOUT: begin
                row.word.rx_valid  = 1'b1;
                row.word.data_byte = $urandom_range(1) ? CH_DEL : CH_BS;
            end
            W_ENTER: begin
                row.word.rx_valid  = 1'b1;
                row.word.data_byte = $urandom_range(1) ? CH_CR : CH_LF;
            end
            W_GET: begin
                row.mode = MODE_GET;
            end
            W_DONE: begin
                row.word.tx_done = 1'b1;
            end
            W_PUT: begin
                row.mode           = MODE_PUT;
                row.word.data_byte = CHAR_W'($urandom_range(255));
            end
            default: begin
                row.mode           = t_mode'($urandom_range(3));
                row.word.rx_valid  = 1'($urandom_range(1));
                row.word.tx_done   = 1'($urandom_range(1));
                row.word.data_byte = CHAR_W'($urandom_range(255));
            end
        endcase
        return row;
    endfunction

    function automatic string fmt_result(input t_line_result r);
        return $sformatf("reply %0b/%h/%h tx %0b/%h put_ref %0b get_ref %0b",
                         r.reply_valid, r.reply_char, r.reply_to, r.tx_valid, r.tx_char,
                         r.put_refused, r.get_refused);
    endfunction

    // present one word, step the model when it is taken
    task automatic send_word(input t_stim_row row);
        t_line_result modelled;
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.word;
        s_axis_tuser  <= row.mode;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        modelled = predict_word(row.mode, row.word);
        pending_results.push_back(row.typed ? row.want : modelled);
        @(negedge i_clk);
    endtask

    // result side back-pressure
    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    // scoreboard
    always @(posedge i_clk) begin : score
        t_line_result got;
        t_line_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_line_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("unexpected result word: %s", fmt_result(got));
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("result mismatch: expected %s", fmt_result(want));
                        $display("                 actual   %s", fmt_result(got));
                    end
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_stim_row directed[$];
        t_segment  seg;
        int        seg_left;
        int        sent;

        // model state after reset
        line_wr        = 0;
        line_rd        = 0;
        lines_ready    = 0;
        line_len       = 0;
        tx_wr          = 0;
        tx_rd          = 0;
        tx_count       = 0;
        reader_pending = 1'b0;
        reader_tag     = '0;
        uart_idle      = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // printable byte goes straight out on an idle transmitter
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, 8'h41, 4'h0, 1'b1,
                                    result_of(1'b0, 8'h00, 4'h0, 1'b1, 8'h41, 1'b0, 1'b0)));
        // top and bottom of the printable range, echoes held back
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, 8'h7E, 4'hF, 1'b1, NO_RESULT));
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, CH_SP, 4'h0, 1'b1, NO_RESULT));
        // control bytes, ctrl-b and high bytes are ignored
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, 8'h1F, 4'h0, 1'b1, NO_RESULT));
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, 8'h02, 4'h0, 1'b1, NO_RESULT));
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, 8'hFF, 4'h0, 1'b1, NO_RESULT));
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, 8'h80, 4'h0, 1'b1, NO_RESULT));
        // del and backspace both rub out
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, CH_DEL, 4'h0, 1'b1, NO_RESULT));
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, CH_BS, 4'h0, 1'b1, NO_RESULT));
        // reader waits, a second one is turned away
        directed.push_back(stim_row(MODE_GET, 1'b0, 1'b0, 8'h00, 4'h5, 1'b1, NO_RESULT));
        directed.push_back(stim_row(MODE_GET, 1'b0, 1'b0, 8'h00, 4'h9, 1'b1,
                                    result_of(1'b0, 8'h00, 4'h0, 1'b0, 8'h00, 1'b0, 1'b1)));
        // carriage return releases the line to the waiting reader
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, CH_CR, 4'h0, 1'b1,
                                    result_of(1'b1, 8'h41, 4'h5, 1'b0, 8'h00, 1'b0, 1'b0)));
        directed.push_back(stim_row(MODE_GET, 1'b0, 1'b0, 8'h00, 4'hF, 1'b1,
                                    result_of(1'b1, CH_LF, 4'hF, 1'b0, 8'h00, 1'b0, 1'b0)));
        // transmitter done, and both flags in one event
        directed.push_back(stim_row(MODE_UART, 1'b0, 1'b1, 8'h00, 4'h0, 1'b0, NO_RESULT));
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b1, 8'h7A, 4'h0, 1'b0, NO_RESULT));
        // puts at the byte extremes
        directed.push_back(stim_row(MODE_PUT, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0, NO_RESULT));
        directed.push_back(stim_row(MODE_PUT, 1'b0, 1'b0, 8'hFF, 4'h0, 1'b0, NO_RESULT));
        // flags outside a uart event mean nothing
        directed.push_back(stim_row(MODE_NOP, 1'b1, 1'b1, 8'hAA, 4'hA, 1'b0, NO_RESULT));
        directed.push_back(stim_row(MODE_PUT, 1'b1, 1'b1, 8'h55, 4'h0, 1'b0, NO_RESULT));
        directed.push_back(stim_row(MODE_GET, 1'b1, 1'b1, CH_CR, 4'h0, 1'b0, NO_RESULT));
        // line feed ends a line too
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, CH_LF, 4'h0, 1'b0, NO_RESULT));
        directed.push_back(stim_row(MODE_UART, 1'b0, 1'b0, 8'h51, 4'h0, 1'b0, NO_RESULT));
        // rubout on an empty line, then a nul byte
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, CH_BS, 4'h0, 1'b0, NO_RESULT));
        directed.push_back(stim_row(MODE_UART, 1'b1, 1'b0, 8'h00, 4'h0, 1'b0, NO_RESULT));

        foreach (directed[i]) begin
            send_word(directed[i]);
        end

        // random runs, idling swapped then switched off
        seg_left = 0;
        seg      = SEG_TYPING;
        for (sent = 0; sent < RANDOM_WORDS; sent++) begin
            if (sent == RANDOM_WORDS / 3) begin
                src_gap_pct  = 60;
                sink_gap_pct = 23;
            end
            if (sent == 2 * RANDOM_WORDS / 3) begin
                src_gap_pct  = 0;
                sink_gap_pct = 0;
            end
            if (seg_left == 0) begin
                seg      = t_segment'($urandom_range(3));
                seg_left = $urandom_range(150, 20);
            end
            send_word(random_word(seg));
            seg_left--;
        end
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray words
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lesb_pkg.sv
rtl/lesb_ram.sv
rtl/lesb_ctrl.sv
rtl/lesb_dp.sv
rtl/line_edit_serial_buffer_core.sv
sim/testbench.sv
